// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define PIDMV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIDMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/pidmv_pkg.sv
// Package for the multi-variant PID controller: constants, register map,
// configuration struct and controller/datapath command types. No dependencies.
`timescale 1ns / 1ps

package pidmv_pkg;

	// Default parameter values.
	localparam int DATA_WIDTH_DEF = 16;
	localparam int GAIN_FRAC_DEF  = 8;

	// Fixed field widths.
	localparam int VAR_W      = 3;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int THR_W      = 16;
	localparam int FILT_W     = 16;
	localparam int ACC_W      = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Variant codes; unused codes behave as plain.
	localparam logic [VAR_W-1:0] VAR_PLAIN     = 3'd0;
	localparam logic [VAR_W-1:0] VAR_SEPARATE  = 3'd1;
	localparam logic [VAR_W-1:0] VAR_WINDUP    = 3'd2;
	localparam logic [VAR_W-1:0] VAR_TRAPEZOID = 3'd3;
	localparam logic [VAR_W-1:0] VAR_FILTER    = 3'd4;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER    = 3'd7;

	typedef struct packed {
		logic [VAR_W-1:0]  variant;
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [LIM_W-1:0]  integral_limit;
		logic [LIM_W-1:0]  output_limit;
		logic [THR_W-1:0]  mode_threshold;
		logic [FILT_W-1:0] deriv_filter;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_D,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_F1,
		ST_MUL_F2,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// Operand pair fed to the shared multiplier.
	typedef enum logic [2:0] {
		MS_D,
		MS_P,
		MS_I,
		MS_F1,
		MS_F2
	} mul_sel_t;

	// Register that takes the previous cycle's product.
	typedef enum logic [2:0] {
		PD_NONE,
		PD_D,
		PD_P,
		PD_I,
		PD_T
	} prod_dst_t;

	typedef struct packed {
		logic      load;
		mul_sel_t  mul_sel;
		prod_dst_t dst;
		logic      update;
		logic      finish;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

// File: sv/pidmv_cfg.sv
// Configuration register file of the PID controller.
// Depends on pidmv_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps

module pidmv_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pidmv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidmv_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pidmv_pkg::cfg_t                   cfg
);

	pidmv_pkg::cfg_t cfg_q;

	// Each write masks the data to the register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.variant        <= pidmv_pkg::VAR_PLAIN;
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.integral_limit <= '1;
			cfg_q.output_limit   <= '1;
			cfg_q.mode_threshold <= '1;
			cfg_q.deriv_filter   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pidmv_pkg::REG_VARIANT: begin
					cfg_q.variant <= cfg_data[pidmv_pkg::VAR_W-1:0];
				end
				pidmv_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data[pidmv_pkg::GAIN_W-1:0];
				end
				pidmv_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data[pidmv_pkg::GAIN_W-1:0];
				end
				pidmv_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data[pidmv_pkg::GAIN_W-1:0];
				end
				pidmv_pkg::REG_INT_LIMIT: begin
					cfg_q.integral_limit <= cfg_data[pidmv_pkg::LIM_W-1:0];
				end
				pidmv_pkg::REG_OUT_LIMIT: begin
					cfg_q.output_limit <= cfg_data[pidmv_pkg::LIM_W-1:0];
				end
				pidmv_pkg::REG_THRESHOLD: begin
					cfg_q.mode_threshold <= cfg_data[pidmv_pkg::THR_W-1:0];
				end
				pidmv_pkg::REG_FILTER: begin
					cfg_q.deriv_filter <= cfg_data[pidmv_pkg::FILT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/pidmv_ctrl.sv
// Controller state machine of the PID controller: sequences the shared
// multiplier, the state update and the result load. Depends on pidmv_pkg.
`timescale 1ns / 1ps

module pidmv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pidmv_pkg::stat_t stat,
	output pidmv_pkg::cmd_t  cmd
);

	pidmv_pkg::state_t state_q;
	pidmv_pkg::state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidmv_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands. Each multiply state issues one
	// product; all but ST_MUL_D also store the product of the previous state.
	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.mul_sel = pidmv_pkg::MS_D;
		cmd.dst     = pidmv_pkg::PD_NONE;
		cmd.update  = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			pidmv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = pidmv_pkg::ST_MUL_D;
				end
			end
			pidmv_pkg::ST_MUL_D: begin
				cmd.mul_sel = pidmv_pkg::MS_D;
				state_nxt   = pidmv_pkg::ST_MUL_P;
			end
			pidmv_pkg::ST_MUL_P: begin
				cmd.mul_sel = pidmv_pkg::MS_P;
				cmd.dst     = pidmv_pkg::PD_D;
				state_nxt   = pidmv_pkg::ST_MUL_I;
			end
			pidmv_pkg::ST_MUL_I: begin
				cmd.mul_sel = pidmv_pkg::MS_I;
				cmd.dst     = pidmv_pkg::PD_P;
				state_nxt   = pidmv_pkg::ST_MUL_F1;
			end
			pidmv_pkg::ST_MUL_F1: begin
				cmd.mul_sel = pidmv_pkg::MS_F1;
				cmd.dst     = pidmv_pkg::PD_I;
				state_nxt   = pidmv_pkg::ST_MUL_F2;
			end
			pidmv_pkg::ST_MUL_F2: begin
				cmd.mul_sel = pidmv_pkg::MS_F2;
				cmd.dst     = pidmv_pkg::PD_T;
				state_nxt   = pidmv_pkg::ST_UPDATE;
			end
			pidmv_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = pidmv_pkg::ST_FINISH;
			end
			pidmv_pkg::ST_FINISH: begin
				// Wait here while the output register still holds an item.
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt  = pidmv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pidmv_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/pidmv_dp.sv
// Datapath of the PID controller: shared multiplier, term registers,
// integral and filter state, output clamp and output register.
// Depends on pidmv_pkg; driven by pidmv_ctrl.
`timescale 1ns / 1ps

module pidmv_dp #(
	parameter int DATA_WIDTH     = pidmv_pkg::DATA_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pidmv_pkg::GAIN_FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pidmv_pkg::cfg_t       cfg,
	input  pidmv_pkg::cmd_t       cmd,
	output pidmv_pkg::stat_t      stat,
	input  logic [DATA_WIDTH-1:0] setpoint,
	input  logic [DATA_WIDTH-1:0] measurement,
	output logic [DATA_WIDTH-1:0] drive,
	output logic                  out_valid,
	input  logic                  out_ready
);

	localparam int ACC_W  = pidmv_pkg::ACC_W;
	localparam int E_W    = DATA_WIDTH + 1;
	localparam int DE_W   = DATA_WIDTH + 2;
	localparam int MA_W   = DE_W + pidmv_pkg::GAIN_W;
	localparam int MB_W   = pidmv_pkg::FILT_W + 2;
	localparam int M_W    = MA_W + MB_W;
	localparam int T_W    = M_W + 1;
	localparam int WIDE_W = (ACC_W > MA_W) ? ACC_W : MA_W;
	localparam int IS_W   = WIDE_W + 1;
	localparam int SUM_W  = WIDE_W + 2;
	localparam int PD_W   = pidmv_pkg::LIM_W + 1;
	localparam int CMP_W  = pidmv_pkg::THR_W + 2;

	localparam logic signed [IS_W-1:0] ACC_HI = IS_W'({1'b0, {(ACC_W-1){1'b1}}});
	localparam logic signed [IS_W-1:0] ACC_LO = -ACC_HI - IS_W'(1);

	// Sample registers.
	logic signed [E_W-1:0]  e_q;
	logic signed [DE_W-1:0] de_q;
	logic signed [DE_W-1:0] es_q;

	// Multiplier and term registers.
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [M_W-1:0]  prod_q;
	logic signed [MA_W-1:0] d_q;
	logic signed [MA_W-1:0] p_q;
	logic signed [MA_W-1:0] gi_q;
	logic signed [M_W-1:0]  t_q;
	logic                   use_i_q;

	// Controller state that persists between items.
	logic signed [ACC_W-1:0] acc_q;
	logic signed [MA_W-1:0]  pderiv_q;
	logic signed [E_W-1:0]   perr_q;
	logic signed [PD_W-1:0]  pdrive_q;

	// Output register.
	logic [DATA_WIDTH-1:0] drive_q;
	logic                  out_valid_q;

	logic signed [E_W-1:0]   e_new;
	logic signed [T_W-1:0]   t_sum;
	logic signed [MA_W-1:0]  dfilt;
	logic signed [MA_W-1:0]  inc;
	logic signed [IS_W-1:0]  isum;
	logic signed [IS_W-1:0]  isat;
	logic signed [ACC_W-1:0] sat_acc;
	logic signed [ACC_W-1:0] ilim;
	logic signed [ACC_W-1:0] clamped_acc;
	logic signed [ACC_W-1:0] acc_nxt;
	logic [E_W-1:0]          mag;
	logic                    mag_ok;
	logic signed [CMP_W-1:0] pdrv_w;
	logic signed [CMP_W-1:0] thr_w;
	logic                    e_pos;
	logic                    integrate;
	logic                    use_i;
	logic signed [SUM_W-1:0] acc_term;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] shifted;
	logic signed [SUM_W-1:0] olim;
	logic signed [SUM_W-1:0] drv;

	// Error of the incoming sample.
	assign e_new = E_W'($signed(setpoint)) - E_W'($signed(measurement));

	// Operand select for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			pidmv_pkg::MS_D: begin
				mul_a = MA_W'(de_q);
				mul_b = $signed({2'b00, cfg.gain_d});
			end
			pidmv_pkg::MS_P: begin
				mul_a = MA_W'(e_q);
				mul_b = $signed({2'b00, cfg.gain_p});
			end
			pidmv_pkg::MS_I: begin
				if (cfg.variant == pidmv_pkg::VAR_TRAPEZOID) begin
					mul_a = MA_W'(es_q);
				end else begin
					mul_a = MA_W'(e_q);
				end
				mul_b = $signed({2'b00, cfg.gain_i});
			end
			pidmv_pkg::MS_F1: begin
				mul_a = d_q;
				mul_b = $signed({2'b01, {pidmv_pkg::FILT_W{1'b0}}})
					- $signed({2'b00, cfg.deriv_filter});
			end
			pidmv_pkg::MS_F2: begin
				mul_a = pderiv_q;
				mul_b = $signed({2'b00, cfg.deriv_filter});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Filtered derivative: weighted sum of both products, floored by 2^16.
	assign t_sum = T_W'(t_q) + T_W'(prod_q);
	assign dfilt = MA_W'(t_sum >>> pidmv_pkg::FILT_W);

	// Integral step: halved product for the trapezoidal form.
	always_comb begin
		if (cfg.variant == pidmv_pkg::VAR_TRAPEZOID) begin
			inc = gi_q >>> 1;
		end else begin
			inc = gi_q;
		end
	end

	assign isum = IS_W'(acc_q) + IS_W'(inc);

	// Saturate to the accumulator range, then, except in the windup variant, to the integral limit.
	always_comb begin
		if (isum > ACC_HI) begin
			isat = ACC_HI;
		end else if (isum < ACC_LO) begin
			isat = ACC_LO;
		end else begin
			isat = isum;
		end
	end

	assign sat_acc = ACC_W'(isat);
	assign ilim    = ACC_W'(cfg.integral_limit) << GAIN_FRAC_BITS;

	always_comb begin
		if (sat_acc > ilim) begin
			clamped_acc = ilim;
		end else if (sat_acc < -ilim) begin
			clamped_acc = -ilim;
		end else begin
			clamped_acc = sat_acc;
		end
	end

	assign acc_nxt = (cfg.variant == pidmv_pkg::VAR_WINDUP) ? sat_acc : clamped_acc;

	// Separation test on the true error magnitude.
	assign mag    = e_q[E_W-1] ? E_W'(-e_q) : E_W'(e_q);
	assign mag_ok = (mag <= E_W'(cfg.mode_threshold));

	// Windup test on the previous drive.
	assign pdrv_w = CMP_W'(pdrive_q);
	assign thr_w  = $signed({2'b00, cfg.mode_threshold});
	assign e_pos  = !e_q[E_W-1] && (e_q != '0);

	always_comb begin
		integrate = 1'b1;
		use_i     = 1'b1;
		case (cfg.variant)
			pidmv_pkg::VAR_SEPARATE: begin
				integrate = mag_ok;
				use_i     = mag_ok;
			end
			pidmv_pkg::VAR_WINDUP: begin
				if (pdrv_w > thr_w) begin
					integrate = !e_pos;
				end else if (pdrv_w < -thr_w) begin
					integrate = e_pos;
				end else begin
					integrate = 1'b1;
				end
			end
			default: begin
				integrate = 1'b1;
			end
		endcase
	end

	// Output sum, floor shift and symmetric clamp.
	always_comb begin
		if (use_i_q) begin
			acc_term = SUM_W'(acc_q);
		end else begin
			acc_term = '0;
		end
	end

	assign sum     = SUM_W'(p_q) + SUM_W'(d_q) + acc_term;
	assign shifted = sum >>> GAIN_FRAC_BITS;
	assign olim    = SUM_W'(cfg.output_limit);

	always_comb begin
		if (shifted > olim) begin
			drv = olim;
		end else if (shifted < -olim) begin
			drv = -olim;
		end else begin
			drv = shifted;
		end
	end

	// Sample and term registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q  <= e_new;
			de_q <= DE_W'(e_new) - DE_W'(perr_q);
			es_q <= DE_W'(e_new) + DE_W'(perr_q);
		end
		prod_q <= mul_a * mul_b;
		case (cmd.dst)
			pidmv_pkg::PD_D: d_q  <= MA_W'(prod_q);
			pidmv_pkg::PD_P: p_q  <= MA_W'(prod_q);
			pidmv_pkg::PD_I: gi_q <= MA_W'(prod_q);
			pidmv_pkg::PD_T: t_q  <= prod_q;
			default: begin
			end
		endcase
		if (cmd.update) begin
			use_i_q <= use_i;
			if (cfg.variant == pidmv_pkg::VAR_FILTER) begin
				d_q <= dfilt;
			end
		end
		if (cmd.finish) begin
			drive_q <= DATA_WIDTH'(drv);
		end
	end

	// Persistent controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pderiv_q <= '0;
			perr_q   <= '0;
			pdrive_q <= '0;
		end else begin
			if (cmd.update) begin
				if (integrate) begin
					acc_q <= acc_nxt;
				end
				if (cfg.variant == pidmv_pkg::VAR_FILTER) begin
					pderiv_q <= dfilt;
				end
			end
			if (cmd.finish) begin
				perr_q   <= e_q;
				pdrive_q <= PD_W'(drv);
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign drive         = drive_q;

endmodule

// File: sv/pid_controller_multi_variant_top.sv
// Top level of the multi-variant positional PID controller.
// Depends on pidmv_pkg, pidmv_cfg, pidmv_ctrl and pidmv_dp.
//
// Usage:
// - Input stream (s_*): one item carries a setpoint and a measurement.
// - Output stream (m_*): one item per input carries the clamped drive.
// - Configuration: cfg_we writes cfg_data into the register at cfg_index
//   on the same clock edge. Write only while no item is in flight.
// - Sequence: after an input is taken the five products (P, I, D and
//   the two filter weights) go one per cycle through a single shared
//   34 x 18 multiplier (default widths), followed by an update state and
//   a result state that waits while the output register is stalled.
// - One item is in flight at a time; s_tready is high only while idle.
// - A finished result sits in an output register, so the next input is
//   taken while it waits. If m_tready stays low the controller holds the
//   following result until the register is free.
// - Reset clears the integral, previous error, previous drive and
//   filtered derivative, and loads the register reset values.
`timescale 1ns / 1ps

module pid_controller_multi_variant_top #(
	parameter int DATA_WIDTH     = pidmv_pkg::DATA_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pidmv_pkg::GAIN_FRAC_DEF,
	localparam int IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_W-1:0]                  s_tdata,   // setpoint, measurement
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata,   // drive
	input  logic                             cfg_we,
	input  logic [pidmv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidmv_pkg::CFG_DATA_W-1:0] cfg_data
);

	pidmv_pkg::cfg_t  cfg;
	pidmv_pkg::cmd_t  cmd;
	pidmv_pkg::stat_t stat;
	logic [DATA_WIDTH-1:0] drive;

	pidmv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pidmv_dp #(
		.DATA_WIDTH     (DATA_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.setpoint    (s_tdata[DATA_WIDTH-1:0]),
		.measurement (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.drive       (drive),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready)
	);

	// Drive in the low bits, zero padding above.
	assign m_tdata = OUT_W'(drive);

endmodule

// File: sv/pidmv_checker.sv
// Port-level checker for the PID controller top level, attached by bind.
// Depends on assert_macros.svh, pidmv_pkg and pid_controller_multi_variant_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidmv_checker #(
	parameter int DATA_WIDTH = pidmv_pkg::DATA_WIDTH_DEF,
	localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// An accepted item keeps the input closed through the working states.
	`PIDMV_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready,
		!s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready
		##1 !s_tready ##1 !s_tready, "input reopened before the item was finished")

	// A new result only appears after the result cycle, never while idle.
	`PIDMV_ASSERT(a_result_from_work, $rose(m_tvalid) |-> $past(!s_tready),
		"result appeared without a finished item")

	// A stalled result holds its value.
	`PIDMV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"stalled result changed or was dropped")

endmodule

bind pid_controller_multi_variant_top pidmv_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_pidmv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
